/* hdl/luas_pkg.sv */
// Package for the least-used adapter selector: sizes, action and status codes,
// request/response words, the search token and the entry update command.
// Depends on nothing; every other file of the block refers to it by scoped names.
package luas_pkg;

   localparam int MAX_ADAPTERS = 8;
   localparam int COUNT_BITS   = 16;
   localparam int IDX_W        = (MAX_ADAPTERS > 1) ? $clog2(MAX_ADAPTERS) : 1;
   localparam int FILL_W       = $clog2(MAX_ADAPTERS + 1);

   localparam logic [1:0] ACT_ADD      = 2'd0;
   localparam logic [1:0] ACT_ACTIVITY = 2'd1;
   localparam logic [1:0] ACT_SELECT   = 2'd2;
   localparam logic [1:0] ACT_DESELECT = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INVALID   = 3'd2;
   localparam logic [2:0] ST_NO_ACTIVE = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   localparam logic [1:0] UPD_ADD  = 2'd0;
   localparam logic [1:0] UPD_FLAG = 2'd1;
   localparam logic [1:0] UPD_INC  = 2'd2;
   localparam logic [1:0] UPD_DEC  = 2'd3;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] adapter_id;
      logic        adapter_active;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] chosen_id;
      logic [15:0] use_count_out;
   } rsp_payload_type;

   // Token that walks the chain: the request plus the running match and minimum.
   typedef struct packed {
      logic             valid;
      logic [1:0]       action;
      logic [63:0]      id;
      logic             active;
      logic             found;
      logic [IDX_W-1:0] found_idx;
      count_type        found_count;
      logic             best_valid;
      logic             best_flag;
      count_type        best_count;
      logic [IDX_W-1:0] best_idx;
      logic [63:0]      best_id;
   } token_type;

   // One entry update, broadcast to all cells after the walk.
   typedef struct packed {
      logic             en;
      logic [1:0]       op;
      logic [IDX_W-1:0] index;
      logic [63:0]      id;
      logic             flag;
   } update_type;

   function automatic count_type sat_inc(input count_type c);
      sat_inc = (c == '1) ? c : c + count_type'(1);
   endfunction

   function automatic logic [15:0] count_out(input count_type c);
      logic [31:0] w;
      w = 32'(c);
      count_out = w[15:0];
   endfunction

endpackage

/* hdl/least_used_adapter_selector_core.sv */
// Top level of the least-used adapter selector: a chain of entry cells and
// the controller that finishes each command. Depends on luas_pkg, luas_cell, luas_ctrl.
//
//   Channel   Ports                         Word moved when
//   --------  ----------------------------  -----------------------------------
//   request   start, busy, req_payload      start high and busy low at the edge
//   response  rsp_strobe, rsp_payload       rsp_strobe high, one cycle each
//
// A command's search token steps through one cell per cycle from acceptance, and
// the controller registers the response and the entry update from the token
// leaving the last cell, so both are shown in the cycle after it leaves.
// Busy drops in the cycle the response is shown, so the next command may be
// accepted at the edge that ends it. Reset is synchronous and active high; it
// empties the table, clears every count and marks every entry inactive. The
// receiver cannot stall, so a response is shown exactly once.
module least_used_adapter_selector_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  luas_pkg::req_payload_type req_payload,
   output logic                      rsp_strobe,
   output luas_pkg::rsp_payload_type rsp_payload
);

   // Token links: link[i] feeds cell i, link[MAX_ADAPTERS] leaves the last cell.
   luas_pkg::token_type         link [luas_pkg::MAX_ADAPTERS+1];
   luas_pkg::update_type        upd;
   logic [luas_pkg::FILL_W-1:0] entries_filled;

   // The token is injected into the first cell at the acceptance edge, with an
   // empty match and an empty running minimum.
   always_comb begin
      link[0]        = '0;
      link[0].valid  = start && !busy;
      link[0].action = req_payload.action;
      link[0].id     = req_payload.adapter_id;
      link[0].active = req_payload.adapter_active;
   end

   for (genvar g = 0; g < luas_pkg::MAX_ADAPTERS; g++) begin : g_cell
      luas_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (luas_pkg::IDX_W'(g)),
         .filled     (luas_pkg::FILL_W'(g) < entries_filled),
         .tok_in     (link[g]),
         .tok_out    (link[g+1]),
         .upd        (upd)
      );
   end

   // The controller turns the finished token into the response word and the
   // single entry write that the command makes.
   luas_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .tok_last       (link[luas_pkg::MAX_ADAPTERS]),
      .entries_filled (entries_filled),
      .upd            (upd),
      .rsp_strobe     (rsp_strobe),
      .rsp_payload    (rsp_payload)
   );

endmodule

/* hdl/luas_cell.sv */
// One cell of the adapter chain: holds one entry and processes the passing token.
// Depends on luas_pkg.
module luas_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [luas_pkg::IDX_W-1:0] cell_index,
   input  logic                       filled,
   input  luas_pkg::token_type        tok_in,
   output luas_pkg::token_type        tok_out,
   input  luas_pkg::update_type       upd
);

   luas_pkg::token_type tok_ff;
   logic [63:0]         id_ff;
   luas_pkg::count_type count_ff;
   logic                inactive_ff;
   logic                hit;
   logic                less;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.action      <= tok_in.action;
      tok_ff.id          <= tok_in.id;
      tok_ff.active      <= tok_in.active;
      tok_ff.found       <= tok_in.found;
      tok_ff.found_idx   <= tok_in.found_idx;
      tok_ff.found_count <= tok_in.found_count;
      tok_ff.best_valid  <= tok_in.best_valid;
      tok_ff.best_flag   <= tok_in.best_flag;
      tok_ff.best_count  <= tok_in.best_count;
      tok_ff.best_idx    <= tok_in.best_idx;
      tok_ff.best_id     <= tok_in.best_id;
   end

   // Entry storage. The id is only ever read once the entry is filled.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         inactive_ff <= 1'b1;
      end else if (upd.en && upd.index == cell_index) begin
         case (upd.op)
            luas_pkg::UPD_ADD: begin
               count_ff    <= '0;
               inactive_ff <= 1'b1;
            end
            luas_pkg::UPD_FLAG: inactive_ff <= upd.flag;
            luas_pkg::UPD_INC:  count_ff <= luas_pkg::sat_inc(count_ff);
            default:            count_ff <= count_ff - luas_pkg::count_type'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en && upd.index == cell_index && upd.op == luas_pkg::UPD_ADD) begin
         id_ff <= upd.id;
      end
   end

   assign hit  = filled && !tok_ff.found && (id_ff == tok_ff.id);
   assign less = (inactive_ff < tok_ff.best_flag) ||
                 ((inactive_ff == tok_ff.best_flag) && (count_ff < tok_ff.best_count));

   always_comb begin
      tok_out = tok_ff;
      if (hit) begin
         tok_out.found       = 1'b1;
         tok_out.found_idx   = cell_index;
         tok_out.found_count = count_ff;
      end
      if (filled && (!tok_ff.best_valid || less)) begin
         tok_out.best_valid = 1'b1;
         tok_out.best_flag  = inactive_ff;
         tok_out.best_count = count_ff;
         tok_out.best_idx   = cell_index;
         tok_out.best_id    = id_ff;
      end
   end

endmodule

/* hdl/luas_ctrl.sv */
// Controller for the adapter chain: tracks busy and the fill count, decides the
// response from the token leaving the last cell and issues the entry update.
// Depends on luas_pkg.
module luas_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  luas_pkg::token_type         tok_last,
   output logic [luas_pkg::FILL_W-1:0] entries_filled,
   output luas_pkg::update_type        upd,
   output logic                        rsp_strobe,
   output luas_pkg::rsp_payload_type   rsp_payload
);

   logic                        busy_ff;
   logic [luas_pkg::FILL_W-1:0] filled_ff, filled_in;
   luas_pkg::update_type        upd_ff, upd_in;
   logic                        strobe_ff;
   luas_pkg::rsp_payload_type   rsp_ff, rsp_in;
   luas_pkg::count_type         inc_found;
   luas_pkg::count_type         inc_best;

   assign inc_found = luas_pkg::sat_inc(tok_last.found_count);
   assign inc_best  = luas_pkg::sat_inc(tok_last.best_count);

   always_comb begin
      filled_in  = filled_ff;
      upd_in     = '0;
      upd_in.id  = tok_last.id;
      rsp_in     = '0;
      unique case (tok_last.action)
         luas_pkg::ACT_ADD: begin
            if (tok_last.id == 64'd0) begin
               rsp_in.status = luas_pkg::ST_INVALID;
            end else if (filled_ff == luas_pkg::FILL_W'(luas_pkg::MAX_ADAPTERS)) begin
               rsp_in.status = luas_pkg::ST_FULL;
            end else begin
               rsp_in.status    = luas_pkg::ST_OK;
               rsp_in.chosen_id = tok_last.id;
               upd_in.en        = 1'b1;
               upd_in.op        = luas_pkg::UPD_ADD;
               upd_in.index     = filled_ff[luas_pkg::IDX_W-1:0];
               filled_in        = filled_ff + luas_pkg::FILL_W'(1);
            end
         end
         luas_pkg::ACT_ACTIVITY: begin
            if (!tok_last.found) begin
               rsp_in.status = luas_pkg::ST_NOT_FOUND;
            end else begin
               rsp_in.status        = luas_pkg::ST_OK;
               rsp_in.chosen_id     = tok_last.id;
               rsp_in.use_count_out = luas_pkg::count_out(tok_last.found_count);
               upd_in.en            = 1'b1;
               upd_in.op            = luas_pkg::UPD_FLAG;
               upd_in.index         = tok_last.found_idx;
               upd_in.flag          = !tok_last.active;
            end
         end
         luas_pkg::ACT_SELECT: begin
            if (tok_last.id != 64'd0) begin
               if (!tok_last.found) begin
                  rsp_in.status = luas_pkg::ST_NOT_FOUND;
               end else begin
                  rsp_in.status        = luas_pkg::ST_OK;
                  rsp_in.chosen_id     = tok_last.id;
                  rsp_in.use_count_out = luas_pkg::count_out(inc_found);
                  upd_in.en            = 1'b1;
                  upd_in.op            = luas_pkg::UPD_INC;
                  upd_in.index         = tok_last.found_idx;
               end
            end else if (!tok_last.best_valid || tok_last.best_flag) begin
               rsp_in.status = luas_pkg::ST_NO_ACTIVE;
            end else begin
               rsp_in.status        = luas_pkg::ST_OK;
               rsp_in.chosen_id     = tok_last.best_id;
               rsp_in.use_count_out = luas_pkg::count_out(inc_best);
               upd_in.en            = 1'b1;
               upd_in.op            = luas_pkg::UPD_INC;
               upd_in.index         = tok_last.best_idx;
            end
         end
         default: begin
            if (tok_last.id == 64'd0) begin
               rsp_in.status = luas_pkg::ST_INVALID;
            end else if (!tok_last.found) begin
               rsp_in.status = luas_pkg::ST_NOT_FOUND;
            end else if (tok_last.found_count == '0) begin
               rsp_in.status = luas_pkg::ST_UNDERFLOW;
            end else begin
               rsp_in.status        = luas_pkg::ST_OK;
               rsp_in.chosen_id     = tok_last.id;
               rsp_in.use_count_out = luas_pkg::count_out(
                  tok_last.found_count - luas_pkg::count_type'(1));
               upd_in.en            = 1'b1;
               upd_in.op            = luas_pkg::UPD_DEC;
               upd_in.index         = tok_last.found_idx;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         filled_ff <= '0;
         upd_ff.en <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (tok_last.valid) begin
            busy_ff   <= 1'b0;
            filled_ff <= filled_in;
         end else if (start && !busy_ff) begin
            busy_ff <= 1'b1;
         end
         upd_ff.en <= tok_last.valid && upd_in.en;
         strobe_ff <= tok_last.valid;
      end
      upd_ff.op    <= upd_in.op;
      upd_ff.index <= upd_in.index;
      upd_ff.id    <= upd_in.id;
      upd_ff.flag  <= upd_in.flag;
      if (tok_last.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy           = busy_ff;
   assign entries_filled = filled_ff;
   assign upd            = upd_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_payload    = rsp_ff;

endmodule
